// ----- sv/modifier_ownership_refcount_macros.svh -----
// Assertion macros used by the checker file.
`ifndef MODIFIER_OWNERSHIP_REFCOUNT_MACROS_SVH
`define MODIFIER_OWNERSHIP_REFCOUNT_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define MOR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset.
`define MOR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset.
`define MOR_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mor_pkg.sv -----
`timescale 1ns / 1ps

package mor_pkg;

  localparam int COUNT_BITS_DEFAULT = 8;
  localparam int MOD_COUNT          = 8;
  localparam int MOD_IDX_BITS       = 3;
  localparam int KEY_BITS           = 16;
  localparam int MASK_BITS          = 8;
  localparam int OP_BITS            = 2;
  localparam int IN_DATA_BITS       = KEY_BITS + 2 * MASK_BITS;
  localparam int OUT_FIELD_BITS     = 2 * MASK_BITS + 2;
  localparam int OUT_DATA_BITS      = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS       = OUT_DATA_BITS - OUT_FIELD_BITS;

  // Modifier keycodes run from LCtrl to RGui.
  localparam logic [KEY_BITS-1:0] FIRST_MOD_KEY = 16'h00E0;

  typedef enum logic [OP_BITS-1:0] {
    OP_PRESS      = 2'd0,
    OP_RELEASE    = 2'd1,
    OP_REGISTER   = 2'd2,
    OP_UNREGISTER = 2'd3
  } op_t;

  // Per-modifier request and response of one item.
  typedef struct packed {
    op_t  op;
    logic hit;
    logic mod_sel;
    logic live;
  } lane_req_t;

  typedef struct packed {
    logic live;
    logic report;
    logic suppress;
    logic owned;
  } lane_rsp_t;

endpackage

// ----- sv/mor_lane.sv -----
`timescale 1ns / 1ps

module mor_lane import mor_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  lane_req_t req,
  output lane_rsp_t rsp
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

  logic [COUNT_BITS-1:0] phys, phys_next;
  logic [COUNT_BITS-1:0] mgd, mgd_next;

  always_comb begin
    phys_next    = phys;
    mgd_next     = mgd;
    rsp.live     = req.live;
    rsp.report   = 1'b0;
    rsp.suppress = 1'b0;
    unique case (req.op)
      OP_PRESS: begin
        if (req.hit && phys != CNT_MAX) phys_next = phys + CNT_ONE;
      end
      OP_RELEASE: begin
        if (req.hit) begin
          if (phys != CNT_ZERO) phys_next = phys - CNT_ONE;
          rsp.suppress = (mgd != CNT_ZERO);
        end
      end
      OP_REGISTER: begin
        if (req.mod_sel) begin
          if (mgd != CNT_MAX) mgd_next = mgd + CNT_ONE;
          // count is nonzero afterwards, so a clear live bit always sets
          if (!req.live) begin
            rsp.live   = 1'b1;
            rsp.report = 1'b1;
          end
        end
      end
      OP_UNREGISTER: begin
        if (req.mod_sel && mgd != CNT_ZERO) begin
          mgd_next = mgd - CNT_ONE;
          // clear counts as an action even if the live bit was already low
          if (mgd == CNT_ONE && phys == CNT_ZERO) begin
            rsp.live   = 1'b0;
            rsp.report = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.owned = (mgd_next != CNT_ZERO) && (phys_next == CNT_ZERO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phys <= '0;
      mgd  <= '0;
    end else if (en) begin
      phys <= phys_next;
      mgd  <= mgd_next;
    end
  end

endmodule

// ----- sv/modifier_ownership_refcount.sv -----
`timescale 1ns / 1ps

// Modifier ownership counter for eight keyboard modifiers (LCtrl..RGui). Each
// modifier keeps a saturating physical-hold count, driven by press and release
// items on keycodes 0xE0..0xE7, and a saturating managed-hold count, driven by
// register and unregister items with a modifier mask. Every item gives exactly
// one result: the updated live modifier byte, a report flag, a
// suppress-default flag for releases of managed modifiers, and the mask of
// modifiers held only by software. One item is accepted per clock cycle while the
// result path is not stalled. After acceptance, an item passes through the input
// register and then the result register, with the eight counter lanes updating
// in between. A stalled result holds the item behind it in the input register,
// and the input stalls once both registers are full and the result is not
// taken. The counts clear in the reset cycle itself; no warm-up is needed.
module modifier_ownership_refcount import mor_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // keycode[15:0], mods[23:16], live_mods[31:24]
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // op[1:0]
  input  logic [OP_BITS-1:0]       s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // new_live_mods[7:0], report_req[8], suppress_default[9], owned_mask[17:10],
  // zero[23:18]
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  logic                    in_valid;
  op_t                     in_op;
  logic [KEY_BITS-1:0]     in_key;
  logic [MASK_BITS-1:0]    in_mods;
  logic [MASK_BITS-1:0]    in_live;
  logic                    advance;
  logic                    key_hit;
  logic [MOD_IDX_BITS-1:0] key_idx;

  lane_req_t [MOD_COUNT-1:0] lane_req;
  lane_rsp_t [MOD_COUNT-1:0] lane_rsp;
  logic [MASK_BITS-1:0]      new_live, report_vec, suppress_vec, owned_vec;

  logic                     out_valid;
  logic [OUT_DATA_BITS-1:0] out_data;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= op_t'(s_tuser);
      in_key  <= s_tdata[KEY_BITS-1:0];
      in_mods <= s_tdata[KEY_BITS +: MASK_BITS];
      in_live <= s_tdata[KEY_BITS+MASK_BITS +: MASK_BITS];
    end
  end

  assign key_hit = (in_key[KEY_BITS-1:MOD_IDX_BITS] == FIRST_MOD_KEY[KEY_BITS-1:MOD_IDX_BITS]);
  assign key_idx = in_key[MOD_IDX_BITS-1:0];

  for (genvar i = 0; i < MOD_COUNT; i++) begin : g_lane
    assign lane_req[i].op      = in_op;
    assign lane_req[i].hit     = key_hit && (key_idx == MOD_IDX_BITS'(i));
    assign lane_req[i].mod_sel = in_mods[i];
    assign lane_req[i].live    = in_live[i];

    mor_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk (clk),
      .rst (rst),
      .en  (advance),
      .req (lane_req[i]),
      .rsp (lane_rsp[i])
    );

    assign new_live[i]     = lane_rsp[i].live;
    assign report_vec[i]   = lane_rsp[i].report;
    assign suppress_vec[i] = lane_rsp[i].suppress;
    assign owned_vec[i]    = lane_rsp[i].owned;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {{OUT_PAD_BITS{1'b0}}, owned_vec, |suppress_vec, |report_vec, new_live};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ----- sv/mor_checker.sv -----
`timescale 1ns / 1ps

`include "modifier_ownership_refcount_macros.svh"

module mor_checker import mor_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [IN_DATA_BITS-1:0]  s_tdata,
  input logic [OP_BITS-1:0]       s_tuser,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata
);

  logic report_bit, suppress_bit;

  assign report_bit   = m_tdata[MASK_BITS];
  assign suppress_bit = m_tdata[MASK_BITS+1];

  // report comes only from register/unregister, suppress only from release
  `MOR_ASSERT_IMP(a_report_xor_suppress, clk, rst, m_tvalid, !(report_bit && suppress_bit), "report and suppress on one item")
  `MOR_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS] == '0, "nonzero pad bits")
  `MOR_ASSERT_NXT_ALWAYS(a_reset_idle, clk, rst, !m_tvalid, "result valid after reset")
  `MOR_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item changed")

endmodule

bind modifier_ownership_refcount mor_checker u_mor_checker (.*);
